// ===== src/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg
// Shared constants and command/status types for the stereo correlation and
// width meter.
// ----------------------------------------------------------------------------
package swm_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int MAG_W       = SAMPLE_BITS + 1;
   localparam int PROD_W      = 2 * MAG_W;
   localparam int MAX_BLOCK   = 4096;
   localparam int CNT_W       = $clog2(MAX_BLOCK + 1);
   localparam int ACC_W       = 60;
   localparam int MEAN_W      = 48;
   localparam int WIN_W       = 18;
   localparam int FLOOR_W     = 16;
   localparam int OUT_W       = 16;
   localparam int ALPHA_W     = 17;
   localparam int ALPHA_ONE   = 65536;
   localparam int ALPHA_MIN   = 655;
   localparam int GATE_LEVEL  = 703688;
   localparam int DB_PER_LOG2 = 197283;
   localparam int DB_MIN_Q8   = -25600;
   localparam int LOG_FRAC    = 24;
   localparam int LOG_EXP_W   = 6;
   localparam int LOG_W       = LOG_EXP_W + LOG_FRAC;
   localparam int DIV_W       = 64;
   localparam int STEP_W      = 7;
   localparam int ROOT_W      = 32;
   localparam int MUL_W       = 32;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 18;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR  = 2'd1;

   localparam logic [WIN_W-1:0]          WINDOW_RESET = 18'd19200;
   localparam logic signed [FLOOR_W-1:0] FLOOR_RESET  = -16'sd15360;

   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] steps;
      logic [DIV_W-1:0]  rem;
      logic [DIV_W-1:0]  dividend;
      logic [DIV_W-1:0]  divisor;
   } swm_div_cmd_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } swm_div_res_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] radicand;
   } swm_sqrt_cmd_type;

   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] root;
   } swm_sqrt_res_type;

endpackage

// ===== src/swm_ifs.sv =====
// ----------------------------------------------------------------------------
// swm_ifs
// Valid/ready channels for stereo sample transactions and meter results.
// ----------------------------------------------------------------------------
interface swm_req_if import swm_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_sample;
   logic signed [SAMPLE_BITS-1:0] right_sample;
   logic                          last_in_block;

   modport source (output valid, output left_sample, output right_sample,
                   output last_in_block, input ready);
   modport sink   (input valid, input left_sample, input right_sample,
                   input last_in_block, output ready);
endinterface

interface swm_rsp_if import swm_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] correlation;
   logic                    correlation_valid;
   logic signed [OUT_W-1:0] width_db;
   logic                    width_valid;

   modport source (output valid, output correlation, output correlation_valid,
                   output width_db, output width_valid, input ready);
   modport sink   (input valid, input correlation, input correlation_valid,
                   input width_db, input width_valid, output ready);
endinterface

// ===== src/swm_mul.sv =====
// ----------------------------------------------------------------------------
// swm_mul
// Shared unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
module swm_mul import swm_pkg::*; (
   input  logic               clock,
   input  logic [MUL_W-1:0]   op_a,
   input  logic [MUL_W-1:0]   op_b,
   output logic [2*MUL_W-1:0] product
);

   logic [2*MUL_W-1:0] prod_ff;
   logic [2*MUL_W-1:0] prod_in;

   assign prod_in = op_a * op_b;
   assign product = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ===== src/swm_div.sv =====
// ----------------------------------------------------------------------------
// swm_div
// Restoring divider, one quotient bit per cycle, with a preset partial
// remainder so it also serves as a fraction divider.
// ----------------------------------------------------------------------------
module swm_div import swm_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  swm_div_cmd_type cmd,
   output swm_div_res_type res
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DIV_W-1:0]  den_ff, den_in;
   logic [DIV_W:0]    trial;
   logic [DIV_W:0]    diffv;
   logic              ge;

   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign diffv = trial - {1'b0, den_ff};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = cmd.steps;
         rem_in  = cmd.rem;
         quo_in  = cmd.dividend;
         den_in  = cmd.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diffv[DIV_W-1:0] : trial[DIV_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign res.done     = done_ff;
   assign res.quotient = quo_ff;

endmodule

// ===== src/swm_sqrt.sv =====
// ----------------------------------------------------------------------------
// swm_sqrt
// Digit-by-digit integer square root of a 64-bit value, one result bit per
// cycle.
// ----------------------------------------------------------------------------
module swm_sqrt import swm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  swm_sqrt_cmd_type cmd,
   output swm_sqrt_res_type res
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DIV_W-1:0] x_ff, x_in;
   logic [DIV_W-1:0] res_ff, res_in;
   logic [DIV_W-1:0] bit_ff, bit_in;
   logic [DIV_W-1:0] tv;
   logic             ge;

   assign tv = res_ff + bit_ff;
   assign ge = x_ff >= tv;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      x_in    = x_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         x_in    = cmd.radicand;
         res_in  = '0;
         bit_in  = DIV_W'(1) << (DIV_W - 2);
      end else if (busy_ff) begin
         x_in   = ge ? x_ff - tv : x_ff;
         res_in = ge ? (res_ff >> 1) + bit_ff : res_ff >> 1;
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff   <= x_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign res.done = done_ff;
   assign res.root = res_ff[ROOT_W-1:0];

endmodule

// ===== src/stereo_correlation_width_meter.sv =====
// ----------------------------------------------------------------------------
// stereo_correlation_width_meter
// Block energy accumulation, exponential smoothing, correlation and stereo
// width in dB, sequenced over one shared multiplier, divider and square root.
// ----------------------------------------------------------------------------
// A sample that does not end a block uses 5 shared multiplies.
// A block-ending sample also runs up to six 64-step divides, two
// 32-step square roots, a 31-step divide and two log2 passes; ready is low
// meanwhile, and longer while a previous result waits in the output register.
// One result transaction per block; the output register frees the sequencer.
// Synchronous active-high reset clears sums, count, smoothed means and
// restores config defaults.
// ----------------------------------------------------------------------------
module stereo_correlation_width_meter import swm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   swm_req_if.sink               req_bus,
   swm_rsp_if.source             rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [5:0] {
      S_IDLE, S_ACC_MUL, S_ACC_ADD, S_ALPHA, S_ALPHA_WAIT, S_MEAN, S_MEAN_WAIT,
      S_DIFF, S_MAG, S_SM_LO, S_SM_HI, S_SM_DELTA, S_SM_UPD, S_GATE, S_SQA,
      S_SQA_WAIT, S_SQB, S_SQB_WAIT, S_DEN_MUL, S_DEN_CHK, S_QDIV_WAIT, S_WID,
      S_LOG_NORM, S_LOG_MUL, S_LOG_STEP, S_DB_ABS, S_DB_MUL, S_DB_FIN,
      S_DB_CLAMP, S_OUT
   } state_type;

   localparam logic [2:0] IX_LL = 3'd0;
   localparam logic [2:0] IX_RR = 3'd1;
   localparam logic [2:0] IX_LR = 3'd2;
   localparam logic [2:0] IX_MM = 3'd3;
   localparam logic [2:0] IX_SS = 3'd4;

   state_type state_ff, state_in;

   logic [WIN_W-1:0]          window_ff;
   logic signed [FLOOR_W-1:0] floor_ff;

   logic [SAMPLE_BITS-1:0] l_mag_ff, l_mag_in;
   logic [SAMPLE_BITS-1:0] r_mag_ff, r_mag_in;
   logic [MAG_W-1:0]       s_mag_ff, s_mag_in;
   logic [MAG_W-1:0]       d_mag_ff, d_mag_in;
   logic                   lr_neg_ff, lr_neg_in;
   logic                   last_ff, last_in;
   logic [2:0]             idx_ff, idx_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;

   logic signed [ACC_W-1:0]  acc_ff [5];
   logic signed [ACC_W-1:0]  acc_in [5];
   logic signed [MEAN_W-1:0] sm_ff  [5];
   logic signed [MEAN_W-1:0] sm_in  [5];

   logic [ALPHA_W-1:0]       alpha_ff, alpha_in;
   logic signed [MEAN_W-1:0] mean_ff, mean_in;
   logic signed [MEAN_W:0]   diff_ff, diff_in;
   logic [MEAN_W-1:0]        smag_ff, smag_in;
   logic                     dneg_ff, dneg_in;
   logic [40:0]              lo_ff, lo_in;
   logic [MEAN_W-1:0]        delta_ff, delta_in;

   logic [ROOT_W-1:0]        sa_ff, sa_in;
   logic [ROOT_W-1:0]        sb_ff, sb_in;
   logic [MEAN_W-1:0]        num_ff, num_in;

   logic [DIV_W-1:0]         norm_ff, norm_in;
   logic [LOG_EXP_W-1:0]     exp_ff, exp_in;
   logic [30:0]              y_ff, y_in;
   logic [LOG_FRAC-1:0]      frac_ff, frac_in;
   logic [4:0]               it_ff, it_in;
   logic                     log_sel_ff, log_sel_in;
   logic [LOG_W-1:0]         log_ss_ff, log_ss_in;
   logic signed [LOG_W:0]    ldiff_ff, ldiff_in;
   logic [LOG_W-1:0]         ldmag_ff, ldmag_in;
   logic                     ldneg_ff, ldneg_in;
   logic signed [17:0]       dbraw_ff, dbraw_in;

   logic signed [OUT_W-1:0]  corr_ff, corr_in;
   logic                     cok_ff, cok_in;
   logic signed [OUT_W-1:0]  db_ff, db_in;
   logic                     wok_ff, wok_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0]  rsp_corr_ff, rsp_corr_in;
   logic                     rsp_cok_ff, rsp_cok_in;
   logic signed [OUT_W-1:0]  rsp_db_ff, rsp_db_in;
   logic                     rsp_wok_ff, rsp_wok_in;

   logic [MUL_W-1:0]   mul_a, mul_b;
   logic [2*MUL_W-1:0] mul_p;
   swm_div_cmd_type    div_cmd;
   swm_div_res_type    div_res;
   swm_sqrt_cmd_type   sq_cmd;
   swm_sqrt_res_type   sq_res;

   logic signed [SAMPLE_BITS-1:0] lv, rv;
   logic signed [MAG_W-1:0]       sv, dv;
   logic [PROD_W-1:0]             prod;
   logic [ACC_W-1:0]              addend;
   logic [ACC_W-1:0]              acc_mag;
   logic [DIV_W-1:0]              qv;
   logic [64:0]                   psum;
   logic signed [MEAN_W:0]        gsum;
   logic [31:0]                   yy;
   logic [LOG_FRAC-1:0]           frac_nx;
   logic [LOG_W-1:0]              logv;
   logic [DIV_W-1:0]              rnd;
   logic signed [17:0]            dbc;
   logic signed [MEAN_W-1:0]      a_v, b_v, c_v, mm_v, ss_v;

   swm_mul u_mul (.clock(clock), .op_a(mul_a), .op_b(mul_b), .product(mul_p));
   swm_div u_div (.clock(clock), .reset(reset), .cmd(div_cmd), .res(div_res));
   swm_sqrt u_sqrt (.clock(clock), .reset(reset), .cmd(sq_cmd), .res(sq_res));

   assign req_bus.ready             = (state_ff == S_IDLE);
   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.correlation       = rsp_corr_ff;
   assign rsp_bus.correlation_valid = rsp_cok_ff;
   assign rsp_bus.width_db          = rsp_db_ff;
   assign rsp_bus.width_valid       = rsp_wok_ff;

   assign a_v  = sm_ff[IX_LL];
   assign b_v  = sm_ff[IX_RR];
   assign c_v  = sm_ff[IX_LR];
   assign mm_v = sm_ff[IX_MM];
   assign ss_v = sm_ff[IX_SS];

   always_comb begin
      state_in     = state_ff;
      l_mag_in     = l_mag_ff;
      r_mag_in     = r_mag_ff;
      s_mag_in     = s_mag_ff;
      d_mag_in     = d_mag_ff;
      lr_neg_in    = lr_neg_ff;
      last_in      = last_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      for (int i = 0; i < 5; i++) begin
         acc_in[i] = acc_ff[i];
         sm_in[i]  = sm_ff[i];
      end
      alpha_in     = alpha_ff;
      mean_in      = mean_ff;
      diff_in      = diff_ff;
      smag_in      = smag_ff;
      dneg_in      = dneg_ff;
      lo_in        = lo_ff;
      delta_in     = delta_ff;
      sa_in        = sa_ff;
      sb_in        = sb_ff;
      num_in       = num_ff;
      norm_in      = norm_ff;
      exp_in       = exp_ff;
      y_in         = y_ff;
      frac_in      = frac_ff;
      it_in        = it_ff;
      log_sel_in   = log_sel_ff;
      log_ss_in    = log_ss_ff;
      ldiff_in     = ldiff_ff;
      ldmag_in     = ldmag_ff;
      ldneg_in     = ldneg_ff;
      dbraw_in     = dbraw_ff;
      corr_in      = corr_ff;
      cok_in       = cok_ff;
      db_in        = db_ff;
      wok_in       = wok_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_bus.ready;
      rsp_corr_in  = rsp_corr_ff;
      rsp_cok_in   = rsp_cok_ff;
      rsp_db_in    = rsp_db_ff;
      rsp_wok_in   = rsp_wok_ff;

      mul_a = '0;
      mul_b = '0;
      div_cmd = '0;
      sq_cmd  = '0;

      lv      = req_bus.left_sample;
      rv      = req_bus.right_sample;
      sv      = MAG_W'(lv) + MAG_W'(rv);
      dv      = MAG_W'(lv) - MAG_W'(rv);
      prod    = mul_p[PROD_W-1:0];
      addend  = (idx_ff >= IX_MM) ? ACC_W'(prod >> 2) : ACC_W'(prod);
      acc_mag = acc_ff[idx_ff][ACC_W-1] ? ACC_W'(-acc_ff[idx_ff])
                                        : ACC_W'(acc_ff[idx_ff]);
      qv      = div_res.quotient;
      psum    = {mul_p[40:0], 24'b0} + 65'(lo_ff);
      gsum    = (MEAN_W+1)'(a_v) + (MEAN_W+1)'(b_v);
      yy      = mul_p[61:30];
      frac_nx = {frac_ff[LOG_FRAC-2:0], yy[31]};
      logv    = {exp_ff, frac_nx};
      rnd     = mul_p + (DIV_W'(1) << 31);
      dbc     = dbraw_ff;
      if (dbc < 18'(DB_MIN_Q8)) dbc = 18'(DB_MIN_Q8);
      if (dbc < 18'(floor_ff))  dbc = 18'(floor_ff);
      if (dbc > 18'sd32767)     dbc = 18'sd32767;

      case (state_ff)
         S_ACC_MUL: begin
            case (idx_ff)
               IX_LL:   begin mul_a = MUL_W'(l_mag_ff); mul_b = MUL_W'(l_mag_ff); end
               IX_RR:   begin mul_a = MUL_W'(r_mag_ff); mul_b = MUL_W'(r_mag_ff); end
               IX_LR:   begin mul_a = MUL_W'(l_mag_ff); mul_b = MUL_W'(r_mag_ff); end
               IX_MM:   begin mul_a = MUL_W'(s_mag_ff); mul_b = MUL_W'(s_mag_ff); end
               default: begin mul_a = MUL_W'(d_mag_ff); mul_b = MUL_W'(d_mag_ff); end
            endcase
         end
         S_SM_LO: begin
            mul_a = MUL_W'(smag_ff[23:0]);
            mul_b = MUL_W'(alpha_ff);
         end
         S_SM_HI: begin
            mul_a = MUL_W'(smag_ff[MEAN_W-1:24]);
            mul_b = MUL_W'(alpha_ff);
         end
         S_DEN_MUL: begin
            mul_a = sa_ff;
            mul_b = sb_ff;
         end
         S_LOG_MUL: begin
            mul_a = MUL_W'(y_ff);
            mul_b = MUL_W'(y_ff);
         end
         S_DB_MUL: begin
            mul_a = MUL_W'(ldmag_ff);
            mul_b = MUL_W'(DB_PER_LOG2);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase

      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               l_mag_in  = lv[SAMPLE_BITS-1] ? SAMPLE_BITS'(-lv) : SAMPLE_BITS'(lv);
               r_mag_in  = rv[SAMPLE_BITS-1] ? SAMPLE_BITS'(-rv) : SAMPLE_BITS'(rv);
               s_mag_in  = sv[MAG_W-1] ? MAG_W'(-sv) : MAG_W'(sv);
               d_mag_in  = dv[MAG_W-1] ? MAG_W'(-dv) : MAG_W'(dv);
               lr_neg_in = lv[SAMPLE_BITS-1] ^ rv[SAMPLE_BITS-1];
               last_in   = req_bus.last_in_block;
               idx_in    = IX_LL;
               state_in  = S_ACC_MUL;
            end
         end
         S_ACC_MUL: state_in = S_ACC_ADD;
         S_ACC_ADD: begin
            if ((idx_ff == IX_LR) && lr_neg_ff)
               acc_in[idx_ff] = acc_ff[idx_ff] - $signed(addend);
            else
               acc_in[idx_ff] = acc_ff[idx_ff] + $signed(addend);
            if (idx_ff == IX_SS) begin
               idx_in = IX_LL;
               cnt_in = cnt_ff + 1'b1;
               if (last_ff || (cnt_ff + 1'b1 == CNT_W'(MAX_BLOCK)))
                  state_in = S_ALPHA;
               else
                  state_in = S_IDLE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_ACC_MUL;
            end
         end
         S_ALPHA: begin
            if (window_ff == '0) begin
               alpha_in = ALPHA_W'(ALPHA_ONE);
               state_in = S_MEAN;
            end else begin
               div_cmd.start    = 1'b1;
               div_cmd.steps    = STEP_W'(DIV_W);
               div_cmd.rem      = '0;
               div_cmd.dividend = DIV_W'({cnt_ff, 16'b0});
               div_cmd.divisor  = DIV_W'(window_ff);
               state_in         = S_ALPHA_WAIT;
            end
         end
         S_ALPHA_WAIT: begin
            if (div_res.done) begin
               if (qv > DIV_W'(ALPHA_ONE))      alpha_in = ALPHA_W'(ALPHA_ONE);
               else if (qv < DIV_W'(ALPHA_MIN)) alpha_in = ALPHA_W'(ALPHA_MIN);
               else                             alpha_in = qv[ALPHA_W-1:0];
               state_in = S_MEAN;
            end
         end
         S_MEAN: begin
            div_cmd.start    = 1'b1;
            div_cmd.steps    = STEP_W'(DIV_W);
            div_cmd.rem      = '0;
            div_cmd.dividend = DIV_W'(acc_mag);
            div_cmd.divisor  = DIV_W'(cnt_ff);
            state_in         = S_MEAN_WAIT;
         end
         S_MEAN_WAIT: begin
            if (div_res.done) begin
               mean_in  = acc_ff[idx_ff][ACC_W-1] ? -$signed(qv[MEAN_W-1:0])
                                                  : $signed(qv[MEAN_W-1:0]);
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            diff_in  = (MEAN_W+1)'(mean_ff) - (MEAN_W+1)'(sm_ff[idx_ff]);
            state_in = S_MAG;
         end
         S_MAG: begin
            dneg_in  = diff_ff[MEAN_W];
            smag_in  = diff_ff[MEAN_W] ? MEAN_W'(-diff_ff) : MEAN_W'(diff_ff);
            state_in = S_SM_LO;
         end
         S_SM_LO: state_in = S_SM_HI;
         S_SM_HI: begin
            lo_in    = mul_p[40:0];
            state_in = S_SM_DELTA;
         end
         S_SM_DELTA: begin
            delta_in = psum[MEAN_W+15:16];
            state_in = S_SM_UPD;
         end
         S_SM_UPD: begin
            if (dneg_ff) sm_in[idx_ff] = sm_ff[idx_ff] - $signed(delta_ff);
            else         sm_in[idx_ff] = sm_ff[idx_ff] + $signed(delta_ff);
            if (idx_ff == IX_SS) begin
               for (int i = 0; i < 5; i++) acc_in[i] = '0;
               cnt_in   = '0;
               idx_in   = IX_LL;
               state_in = S_GATE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_MEAN;
            end
         end
         S_GATE: begin
            corr_in = '0;
            cok_in  = 1'b0;
            db_in   = '0;
            wok_in  = 1'b0;
            if (gsum < (MEAN_W+1)'(GATE_LEVEL)) begin
               state_in = S_OUT;
            end else begin
               wok_in = 1'b1;
               if ((a_v > 0) && (b_v > 0)) state_in = S_SQA;
               else                        state_in = S_WID;
            end
         end
         S_SQA: begin
            sq_cmd.start    = 1'b1;
            sq_cmd.radicand = {a_v, 16'b0};
            state_in        = S_SQA_WAIT;
         end
         S_SQA_WAIT: begin
            if (sq_res.done) begin
               sa_in    = sq_res.root;
               state_in = S_SQB;
            end
         end
         S_SQB: begin
            sq_cmd.start    = 1'b1;
            sq_cmd.radicand = {b_v, 16'b0};
            state_in        = S_SQB_WAIT;
         end
         S_SQB_WAIT: begin
            if (sq_res.done) begin
               sb_in    = sq_res.root;
               state_in = S_DEN_MUL;
            end
         end
         S_DEN_MUL: begin
            num_in   = c_v[MEAN_W-1] ? MEAN_W'(-c_v) : MEAN_W'(c_v);
            state_in = S_DEN_CHK;
         end
         S_DEN_CHK: begin
            if (DIV_W'(num_ff) >= mul_p) begin
               corr_in  = c_v[MEAN_W-1] ? -16'sd32768 : 16'sd32767;
               cok_in   = 1'b1;
               state_in = S_WID;
            end else begin
               div_cmd.start    = 1'b1;
               div_cmd.steps    = STEP_W'(31);
               div_cmd.rem      = DIV_W'(num_ff);
               div_cmd.dividend = '0;
               div_cmd.divisor  = mul_p;
               state_in         = S_QDIV_WAIT;
            end
         end
         S_QDIV_WAIT: begin
            if (div_res.done) begin
               if (c_v[MEAN_W-1]) begin
                  if (qv[31:0] >= 32'd32768) corr_in = -16'sd32768;
                  else corr_in = -$signed(OUT_W'(qv[14:0]));
               end else begin
                  if (qv[31:0] >= 32'd32767) corr_in = 16'sd32767;
                  else corr_in = $signed(OUT_W'(qv[14:0]));
               end
               cok_in   = 1'b1;
               state_in = S_WID;
            end
         end
         S_WID: begin
            if (mm_v > 0) begin
               if (ss_v <= 0) begin
                  dbraw_in = 18'(DB_MIN_Q8);
                  state_in = S_DB_CLAMP;
               end else begin
                  norm_in    = DIV_W'(ss_v);
                  exp_in     = LOG_EXP_W'(63);
                  log_sel_in = 1'b0;
                  state_in   = S_LOG_NORM;
               end
            end else begin
               state_in = S_OUT;
            end
         end
         S_LOG_NORM: begin
            if (norm_ff[DIV_W-1]) begin
               y_in     = norm_ff[DIV_W-1:33];
               frac_in  = '0;
               it_in    = '0;
               state_in = S_LOG_MUL;
            end else begin
               norm_in = norm_ff << 1;
               exp_in  = exp_ff - 1'b1;
            end
         end
         S_LOG_MUL: state_in = S_LOG_STEP;
         S_LOG_STEP: begin
            y_in    = yy[31] ? yy[31:1] : yy[30:0];
            frac_in = frac_nx;
            if (it_ff == 5'(LOG_FRAC - 1)) begin
               if (!log_sel_ff) begin
                  log_ss_in  = logv;
                  norm_in    = DIV_W'(mm_v);
                  exp_in     = LOG_EXP_W'(63);
                  log_sel_in = 1'b1;
                  state_in   = S_LOG_NORM;
               end else begin
                  ldiff_in = (LOG_W+1)'(log_ss_ff) - (LOG_W+1)'(logv);
                  state_in = S_DB_ABS;
               end
            end else begin
               it_in    = it_ff + 1'b1;
               state_in = S_LOG_MUL;
            end
         end
         S_DB_ABS: begin
            ldneg_in = ldiff_ff[LOG_W];
            ldmag_in = ldiff_ff[LOG_W] ? LOG_W'(-ldiff_ff) : LOG_W'(ldiff_ff);
            state_in = S_DB_MUL;
         end
         S_DB_MUL: state_in = S_DB_FIN;
         S_DB_FIN: begin
            dbraw_in = ldneg_ff ? -$signed({1'b0, rnd[48:32]})
                                : $signed({1'b0, rnd[48:32]});
            state_in = S_DB_CLAMP;
         end
         S_DB_CLAMP: begin
            db_in    = OUT_W'(dbc);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_corr_in  = corr_ff;
               rsp_cok_in   = cok_ff;
               rsp_db_in    = db_ff;
               rsp_wok_in   = wok_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         floor_ff  <= FLOOR_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WINDOW: window_ff <= csr_wdata[WIN_W-1:0];
            CSR_FLOOR:  floor_ff  <= $signed(csr_wdata[FLOOR_W-1:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= IX_LL;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 5; i++) begin
            acc_ff[i] <= '0;
            sm_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < 5; i++) begin
            acc_ff[i] <= acc_in[i];
            sm_ff[i]  <= sm_in[i];
         end
      end
      l_mag_ff    <= l_mag_in;
      r_mag_ff    <= r_mag_in;
      s_mag_ff    <= s_mag_in;
      d_mag_ff    <= d_mag_in;
      lr_neg_ff   <= lr_neg_in;
      last_ff     <= last_in;
      alpha_ff    <= alpha_in;
      mean_ff     <= mean_in;
      diff_ff     <= diff_in;
      smag_ff     <= smag_in;
      dneg_ff     <= dneg_in;
      lo_ff       <= lo_in;
      delta_ff    <= delta_in;
      sa_ff       <= sa_in;
      sb_ff       <= sb_in;
      num_ff      <= num_in;
      norm_ff     <= norm_in;
      exp_ff      <= exp_in;
      y_ff        <= y_in;
      frac_ff     <= frac_in;
      it_ff       <= it_in;
      log_sel_ff  <= log_sel_in;
      log_ss_ff   <= log_ss_in;
      ldiff_ff    <= ldiff_in;
      ldmag_ff    <= ldmag_in;
      ldneg_ff    <= ldneg_in;
      dbraw_ff    <= dbraw_in;
      corr_ff     <= corr_in;
      cok_ff      <= cok_in;
      db_ff       <= db_in;
      wok_ff      <= wok_in;
      rsp_corr_ff <= rsp_corr_in;
      rsp_cok_ff  <= rsp_cok_in;
      rsp_db_ff   <= rsp_db_in;
      rsp_wok_ff  <= rsp_wok_in;
   end

endmodule
